// ===== rtl/bist_pkg.sv =====
// ----------------------------------------------------------------------------
// bist_pkg
// Shared widths, operation codes and defaults for the bounded integer set table.
// ----------------------------------------------------------------------------
`default_nettype none

package bist_pkg;

    // payload widths fixed by the request and result formats
    localparam int MODE_W  = 2;
    localparam int VALUE_W = 32;
    localparam int COUNT_W = 5;

    // default table depth
    localparam int MAX_ENTRIES_DEF = 16;

    // operation codes
    localparam logic [MODE_W-1:0] MODE_ADD      = 2'd0;
    localparam logic [MODE_W-1:0] MODE_REMOVE   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CONTAINS = 2'd2;
    localparam logic [MODE_W-1:0] MODE_CLEAR    = 2'd3;

    typedef logic [MODE_W-1:0]         mode_t;
    typedef logic signed [VALUE_W-1:0] value_t;
    typedef logic [COUNT_W-1:0]        count_t;

endpackage

`default_nettype wire

// ===== rtl/bist_if.sv =====
// ----------------------------------------------------------------------------
// bist_if
// Valid/ready channels for set table requests and results.
// ----------------------------------------------------------------------------
`default_nettype none

// request channel: operation and value
interface bist_req_if
    import bist_pkg::*;
;
    logic   valid;
    logic   ready;
    mode_t  mode;
    value_t value;

    modport source (output valid, output mode, output value, input ready);
    modport sink   (input valid, input mode, input value, output ready);
endinterface

// result channel: status and entry count after the operation
interface bist_resp_if
    import bist_pkg::*;
;
    logic   valid;
    logic   ready;
    logic   found;
    logic   error_full;
    count_t count;
    logic   empty_res;

    modport source (output valid, output found, output error_full, output count,
                    output empty_res, input ready);
    modport sink   (input valid, input found, input error_full, input count,
                    input empty_res, output ready);
endinterface

`default_nettype wire

// ===== rtl/bounded_int_set_table_unit.sv =====
// ----------------------------------------------------------------------------
// bounded_int_set_table_unit
// Unordered set of signed 32-bit values with add, remove-all, contains, clear.
// ----------------------------------------------------------------------------
// Holds up to MAX_ENTRIES values in a RAM with an entry count. Add and clear
// finish in the cycle the request is taken, so they run one request per cycle.
// Contains and remove walk the stored entries through the single RAM read
// port and one equality comparator, one entry per cycle: a contains takes
// up to count + 1 cycles, and a remove takes one more cycle for each copy it
// deletes, since the last entry must be read before it fills the hole.
// The request channel is held off while a search runs; a finished result
// sits in an output register and the next request is taken as it drains.
`default_nettype none

module bounded_int_set_table_unit
    import bist_pkg::*;
#(
    parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
    input wire logic      clk,
    input wire logic      rst_n,
    bist_req_if.sink      req,
    bist_resp_if.source   resp
);

    localparam int ADDR_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);

    // sequencer states
    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SEARCH = 2'd1;
    localparam logic [1:0] ST_MOVE   = 2'd2;

    logic [1:0]        state_reg, state_next;
    logic [ADDR_W-1:0] idx_reg, idx_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [VALUE_W-1:0] key_reg, key_next;
    logic              remove_reg, remove_next;
    logic              found_reg, found_next;

    logic              out_valid_reg, out_valid_next;
    logic              out_found_reg, out_found_next;
    logic              out_err_reg, out_err_next;
    count_t            out_count_reg, out_count_next;
    logic              out_empty_reg, out_empty_next;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [VALUE_W-1:0] ram_wdata;
    logic [ADDR_W-1:0] ram_raddr;
    logic [VALUE_W-1:0] ram_rdata;

    logic              req_fire;
    logic              finish;
    logic              fin_err;
    logic              match;
    logic [CNT_W-1:0]  next_pos;

    // entry storage
    bist_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (MAX_ENTRIES)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // shared comparator and walk position
    assign match    = (ram_rdata == key_reg);
    assign next_pos = CNT_W'(idx_reg) + CNT_W'(1);

    // handshakes
    assign req.ready = (state_reg == ST_IDLE) && (!out_valid_reg || resp.ready);
    assign req_fire  = req.valid && req.ready;

    // sequencer
    always_comb
    begin
        state_next  = state_reg;
        idx_next    = idx_reg;
        count_next  = count_reg;
        key_next    = key_reg;
        remove_next = remove_reg;
        found_next  = found_reg;
        ram_we      = 1'b0;
        ram_waddr   = idx_reg;
        ram_wdata   = ram_rdata;
        ram_raddr   = '0;
        finish      = 1'b0;
        fin_err     = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (req_fire)
                begin
                    key_next    = req.value;
                    remove_next = (req.mode == MODE_REMOVE);
                    found_next  = 1'b0;
                    idx_next    = '0;
                    case (req.mode)
                        MODE_ADD:
                        begin
                            finish = 1'b1;
                            if (count_reg >= CNT_W'(MAX_ENTRIES))
                            begin
                                fin_err = 1'b1;
                            end
                            else
                            begin
                                ram_we     = 1'b1;
                                ram_waddr  = ADDR_W'(count_reg);
                                ram_wdata  = req.value;
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        MODE_REMOVE, MODE_CONTAINS:
                        begin
                            if (count_reg == '0)
                            begin
                                finish = 1'b1;
                            end
                            else
                            begin
                                ram_raddr  = '0;
                                state_next = ST_SEARCH;
                            end
                        end
                        MODE_CLEAR:
                        begin
                            count_next = '0;
                            finish     = 1'b1;
                        end
                        default:
                        begin
                            finish = 1'b1;
                        end
                    endcase
                end
            end

            // read data holds the entry at idx_reg
            ST_SEARCH:
            begin
                ram_raddr = ADDR_W'(next_pos);
                if (match)
                begin
                    found_next = 1'b1;
                    if (remove_reg)
                    begin
                        count_next = count_reg - CNT_W'(1);
                        ram_raddr  = ADDR_W'(count_reg - CNT_W'(1));
                        state_next = ST_MOVE;
                    end
                    else
                    begin
                        finish = 1'b1;
                    end
                end
                else if (next_pos >= count_reg)
                begin
                    finish = 1'b1;
                end
                else
                begin
                    idx_next = ADDR_W'(next_pos);
                end
            end

            // read data holds the last entry, which fills the hole at idx_reg
            ST_MOVE:
            begin
                ram_we    = 1'b1;
                ram_waddr = idx_reg;
                ram_wdata = ram_rdata;
                ram_raddr = ADDR_W'(next_pos);
                if (CNT_W'(idx_reg) >= count_reg)
                begin
                    finish = 1'b1;
                end
                else if (match)
                begin
                    count_next = count_reg - CNT_W'(1);
                    ram_raddr  = ADDR_W'(count_reg - CNT_W'(1));
                end
                else if (next_pos >= count_reg)
                begin
                    finish = 1'b1;
                end
                else
                begin
                    idx_next   = ADDR_W'(next_pos);
                    state_next = ST_SEARCH;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (finish)
        begin
            state_next = ST_IDLE;
        end
    end

    // result register
    always_comb
    begin
        out_valid_next = out_valid_reg && !resp.ready;
        out_found_next = out_found_reg;
        out_err_next   = out_err_reg;
        out_count_next = out_count_reg;
        out_empty_next = out_empty_reg;
        if (finish)
        begin
            out_valid_next = 1'b1;
            out_found_next = found_next;
            out_err_next   = fin_err;
            out_count_next = COUNT_W'(count_next);
            out_empty_next = (count_next == '0);
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // working and payload registers
    always_ff @(posedge clk)
    begin
        idx_reg       <= idx_next;
        key_reg       <= key_next;
        remove_reg    <= remove_next;
        found_reg     <= found_next;
        out_found_reg <= out_found_next;
        out_err_reg   <= out_err_next;
        out_count_reg <= out_count_next;
        out_empty_reg <= out_empty_next;
    end

    assign resp.valid      = out_valid_reg;
    assign resp.found      = out_found_reg;
    assign resp.error_full = out_err_reg;
    assign resp.count      = out_count_reg;
    assign resp.empty_res  = out_empty_reg;

    // entry count never passes the table depth
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_ENTRIES))
        else $error("entry count above table depth");

    // the walk only visits stored entries
    a_search_idx: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SEARCH) |-> (CNT_W'(idx_reg) < count_reg))
        else $error("search index beyond entry count");

    // a taken request either starts a walk or leaves a result
    a_req_progress: assert property (@(posedge clk) disable iff (!rst_n)
        req_fire |=> (state_reg != ST_IDLE) || resp.valid)
        else $error("request taken without work or result");

    // a walk never grows the set
    a_walk_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |=> (count_reg <= $past(count_reg)))
        else $error("entry count grew during a search");

endmodule

`default_nettype wire

// ===== rtl/bist_ram.sv =====
// ----------------------------------------------------------------------------
// bist_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module bist_ram #(
    parameter  int WIDTH  = 32,
    parameter  int DEPTH  = 16,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read, old data on a same-address write
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== tb/bounded_int_set_table_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_int_set_table_unit_tb
// Self-checking bench for the bounded integer set table.
// ----------------------------------------------------------------------------
// A short table of directed requests covers the empty set, the value
// extremes, duplicates, a full set and clear. About a thousand random
// requests follow. Every response is checked field by field against the
// directed table or an in-bench copy of the set. The sender works in bursts
// and the receiver stalls on its own pattern. Twice the receiver holds off
// long enough to back it up, and three times the sender lets the table drain.
// ----------------------------------------------------------------------------

module bounded_int_set_table_unit_tb
    import bist_pkg::*;
;

    localparam int N_RANDOM     = 1030;
    localparam int STALL_LIMIT  = 3000;
    localparam int LONG_HOLD    = 500;
    localparam int TAIL_CYCLES  = 40;
    localparam int MAX_SHOWN    = 10;

    typedef struct packed {
        logic   found;
        logic   error_full;
        count_t count;
        logic   empty_res;
    } set_result_t;

    typedef struct packed {
        mode_t       op;
        value_t      val;
        logic [7:0]  reps;
        logic        typed;
        set_result_t want;
    } dir_row_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    bist_req_if  req_ch ();
    bist_resp_if resp_ch ();

    bounded_int_set_table_unit dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .resp  (resp_ch)
    );

    always #6 clk = ~clk;

    // shadow copy of the set contents
    value_t      stored_vals [MAX_ENTRIES_DEF];
    int          stored_count = 0;

    set_result_t pending_results [$];
    dir_row_t    directed_ops [$];
    int          fail_count   = 0;
    int          results_seen = 0;
    int          burst_left   = 0;

    // first slot at or after start holding key, or stored_count if none
    function automatic int find_stored(value_t key, int start);
        int i;
        for (i = start; i < stored_count; i++)
        begin
            if (stored_vals[i] == key)
                return i;
        end
        return stored_count;
    endfunction

    // apply one operation to the shadow set and return its response
    function automatic set_result_t apply_set_op(mode_t op, value_t key);
        set_result_t r;
        int          pos;
        r = '0;
        case (op)
            MODE_ADD:
            begin
                if (stored_count >= MAX_ENTRIES_DEF)
                    r.error_full = 1'b1;
                else
                begin
                    stored_vals[stored_count] = key;
                    stored_count++;
                end
            end
            MODE_REMOVE:
            begin
                // last entry fills each hole, then search again from the hole
                pos = find_stored(key, 0);
                while (pos < stored_count)
                begin
                    r.found = 1'b1;
                    stored_count--;
                    stored_vals[pos] = stored_vals[stored_count];
                    pos = find_stored(key, pos);
                end
            end
            MODE_CONTAINS:
                r.found = (find_stored(key, 0) < stored_count);
            default:
                stored_count = 0;
        endcase
        r.count     = count_t'(stored_count);
        r.empty_res = (stored_count == 0);
        return r;
    endfunction

    task automatic add_row(mode_t op, value_t val, int reps, logic typed,
                           int f, int e, int c, int em);
        dir_row_t row;
        row.op              = op;
        row.val             = val;
        row.reps            = reps[7:0];
        row.typed           = typed;
        row.want.found      = f[0];
        row.want.error_full = e[0];
        row.want.count      = count_t'(c);
        row.want.empty_res  = em[0];
        directed_ops.push_back(row);
    endtask

    // offer one request in bursts with random gaps, predict on acceptance
    task automatic send_req(mode_t op, value_t val, logic typed, set_result_t want);
        int          gap;
        set_result_t exp_res;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            burst_left = $urandom_range(1, 40);
            if (gap > 0)
            begin
                req_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        req_ch.valid <= 1'b1;
        req_ch.mode  <= op;
        req_ch.value <= val;
        @(posedge clk);
        while (!(req_ch.valid && req_ch.ready))
            @(posedge clk);
        exp_res = apply_set_op(op, val);
        if (typed)
            exp_res = want;
        pending_results.push_back(exp_res);
    endtask

    // stop offering until every outstanding response has come back
    task automatic drain_results();
        req_ch.valid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    function automatic value_t pick_value();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 60)
        begin
            case ($urandom_range(0, 7))
                0: return value_t'(32'h8000_0000);
                1: return value_t'(32'h7fff_ffff);
                2: return value_t'(-1);
                3: return value_t'(0);
                4: return value_t'(1);
                5: return value_t'(32'h5a5a_a5a5);
                6: return value_t'(-7);
                default: return value_t'(42);
            endcase
        end
        else if (sel < 75)
            return value_t'($urandom_range(0, 15));
        return value_t'($urandom);
    endfunction

    // growing phases favor add, shrinking phases favor remove
    function automatic mode_t pick_mode(bit growing);
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 2)
            return MODE_CLEAR;
        if (growing)
        begin
            if (sel < 62)
                return MODE_ADD;
            else if (sel < 78)
                return MODE_REMOVE;
            return MODE_CONTAINS;
        end
        if (sel < 25)
            return MODE_ADD;
        else if (sel < 65)
            return MODE_REMOVE;
        return MODE_CONTAINS;
    endfunction

    // response check against the oldest expectation
    always @(posedge clk)
    begin
        set_result_t got;
        set_result_t exp_res;
        if (rst_n && resp_ch.valid && resp_ch.ready)
        begin
            got.found      = resp_ch.found;
            got.error_full = resp_ch.error_full;
            got.count      = resp_ch.count;
            got.empty_res  = resp_ch.empty_res;
            results_seen++;
            if (pending_results.size() == 0)
            begin
                fail_count++;
                if (fail_count <= MAX_SHOWN)
                    $display("%0t: response with none pending: found=%0b err=%0b %s",
                             $realtime, got.found, got.error_full,
                             $sformatf("cnt=%0d empty=%0b", got.count, got.empty_res));
            end
            else
            begin
                exp_res = pending_results.pop_front();
                if (got.found !== exp_res.found || got.error_full !== exp_res.error_full ||
                    got.count !== exp_res.count || got.empty_res !== exp_res.empty_res)
                begin
                    fail_count++;
                    if (fail_count <= MAX_SHOWN)
                        $display("%0t: mismatch exp found=%0b err=%0b cnt=%0d empty=%0b, %s",
                                 $realtime, exp_res.found, exp_res.error_full,
                                 exp_res.count, exp_res.empty_res,
                                 $sformatf("got found=%0b err=%0b cnt=%0d empty=%0b",
                                           got.found, got.error_full, got.count,
                                           got.empty_res));
                end
            end
        end
    end

    // watchdog on cycles with no handshake on either channel
    always @(posedge clk)
    begin
        int idle_cycles;
        if (!rst_n || (req_ch.valid && req_ch.ready) || (resp_ch.valid && resp_ch.ready))
            idle_cycles = 0;
        else
        begin
            idle_cycles++;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("[bounded_int_set_table_unit] ERROR");
                $finish;
            end
        end
    end

    // receiver: changing stall styles plus two long hold-offs
    initial
    begin
        int hold_left;
        int holds_done;
        int style;
        int style_left;
        int cyc;
        hold_left  = 0;
        holds_done = 0;
        style      = 0;
        style_left = 0;
        cyc        = 0;
        resp_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            cyc++;
            if (hold_left == 0 && holds_done < 2 && results_seen >= 300 + 400 * holds_done)
            begin
                hold_left = LONG_HOLD;
                holds_done++;
            end
            if (style_left == 0)
            begin
                style      = $urandom_range(0, 3);
                style_left = $urandom_range(20, 120);
            end
            style_left--;
            if (hold_left > 0)
            begin
                hold_left--;
                resp_ch.ready <= 1'b0;
            end
            else
            begin
                case (style)
                    0: resp_ch.ready <= 1'b1;
                    1: resp_ch.ready <= 1'($urandom_range(0, 1));
                    2: resp_ch.ready <= (cyc % 4 == 0);
                    default: resp_ch.ready <= ($urandom_range(0, 9) != 0);
                endcase
            end
        end
    end

    // stimulus
    initial
    begin
        int          k;
        int          j;
        int          phase_left;
        bit          growing;
        dir_row_t    row;
        req_ch.valid = 1'b0;
        req_ch.mode  = MODE_ADD;
        req_ch.value = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty set, extremes, duplicates up to full, overflow, remove-all, clear
        add_row(MODE_CONTAINS, value_t'(0),            1, 1'b1, 0, 0,  0, 1);
        add_row(MODE_REMOVE,   value_t'(5),            1, 1'b1, 0, 0,  0, 1);
        add_row(MODE_ADD,      value_t'(32'h8000_0000), 1, 1'b1, 0, 0,  1, 0);
        add_row(MODE_ADD,      value_t'(32'h7fff_ffff), 1, 1'b1, 0, 0,  2, 0);
        add_row(MODE_ADD,      value_t'(-1),           1, 1'b1, 0, 0,  3, 0);
        add_row(MODE_CONTAINS, value_t'(32'h8000_0000), 1, 1'b1, 1, 0,  3, 0);
        add_row(MODE_ADD,      value_t'(0),           13, 1'b0, 0, 0,  0, 0);
        add_row(MODE_ADD,      value_t'(1),            1, 1'b1, 0, 1, 16, 0);
        add_row(MODE_CONTAINS, value_t'(0),            1, 1'b1, 1, 0, 16, 0);
        add_row(MODE_REMOVE,   value_t'(2),            1, 1'b1, 0, 0, 16, 0);
        add_row(MODE_REMOVE,   value_t'(0),            1, 1'b1, 1, 0,  3, 0);
        add_row(MODE_CONTAINS, value_t'(0),            1, 1'b1, 0, 0,  3, 0);
        add_row(MODE_REMOVE,   value_t'(-1),           1, 1'b1, 1, 0,  2, 0);
        add_row(MODE_CLEAR,    value_t'(-1),           1, 1'b1, 0, 0,  0, 1);
        add_row(MODE_CLEAR,    value_t'(32'h7fff_ffff), 1, 1'b1, 0, 0,  0, 1);

        foreach (directed_ops[i])
        begin
            row = directed_ops[i];
            for (j = 0; j < row.reps; j++)
                send_req(row.op, row.val, row.typed, row.want);
        end
        drain_results();

        // random part in growing and shrinking phases
        growing    = 1'b1;
        phase_left = 0;
        for (k = 0; k < N_RANDOM; k++)
        begin
            if (k == N_RANDOM / 2)
                drain_results();
            if (phase_left == 0)
            begin
                growing    = $urandom_range(0, 1);
                phase_left = $urandom_range(20, 80);
            end
            phase_left--;
            send_req(pick_mode(growing), pick_value(), 1'b0, '0);
        end

        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("[bounded_int_set_table_unit] OK");
        else
            $display("[bounded_int_set_table_unit] ERROR");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/bist_pkg.sv
rtl/bist_if.sv
rtl/bist_ram.sv
rtl/bounded_int_set_table_unit.sv
tb/bounded_int_set_table_unit_tb.sv
